// File: src/sfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Shared constants, operation codes and the control/status bundles that pass
// between the sequencer controller and its datapath.
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int MAX_FRAMES_DEFAULT  = 64;
   localparam int MAX_CATCHUP_DEFAULT = 5;

   // frame index and sequence length (length register is 7 bits)
   localparam int FRAME_W   = 7;
   localparam int DUR_MS_W  = 16;
   localparam int DUR_US_W  = 26;
   localparam int US_PER_MS = 1000;

   // remainder unit for frame stepping: magnitude of frame plus amount
   localparam int MOD_BITS  = 8;
   localparam int MOD_CNT_W = 4;

   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_LOAD    = 3'd1;
   localparam logic [2:0] OP_RESTART = 3'd2;
   localparam logic [2:0] OP_STEP    = 3'd3;
   localparam logic [2:0] OP_SET     = 3'd4;

   typedef struct packed {
      logic [FRAME_W-1:0] seq_length;
      logic               looping;
      logic signed [15:0] speed;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic dispatch;
      logic mod_step;
      logic mod_apply;
      logic tick_add;
      logic rd_cur;
      logic fwd_step;
      logic rd_back;
      logic bwd_apply;
      logic sum_issue;
      logic sum_final;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       step_zero;
      logic       mod_done;
      logic       ft_neg;
      logic       fwd_go;
      logic       bwd_go;
      logic       wrap_loop;
      logic       sum_more;
      logic       pipe_busy;
   } status_type;

endpackage
`default_nettype wire

// File: src/sfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: src/sfs_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite frame sequencer registers
// APB register file: sequence length, looping and playback speed.
// ----------------------------------------------------------------------------
module sfs_csr
   import sfs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready,
   output cfg_type                 cfg
);

   localparam logic [1:0] REG_LENGTH  = 2'd0;
   localparam logic [1:0] REG_LOOPING = 2'd1;
   localparam logic [1:0] REG_SPEED   = 2'd2;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite && pready;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_LENGTH:  cfg_in.seq_length = pwdata[FRAME_W-1:0];
            REG_LOOPING: cfg_in.looping    = pwdata[0];
            REG_SPEED:   cfg_in.speed      = $signed(pwdata[15:0]);
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_LENGTH:  prdata = {{(PDATA_W-FRAME_W){1'b0}}, cfg_ff.seq_length};
         REG_LOOPING: prdata = {{(PDATA_W-1){1'b0}}, cfg_ff.looping};
         REG_SPEED:   prdata = {{(PDATA_W-16){1'b0}}, cfg_ff.speed};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seq_length <= FRAME_W'(1);
         cfg_ff.looping    <= 1'b1;
         cfg_ff.speed      <= 16'sd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: src/sfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite frame sequencer controller
// Sequences one item through dispatch, remainder, tick catch-up and
// backward-wrap summation, and issues the result strobe.
// ----------------------------------------------------------------------------
module sfs_ctrl
   import sfs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output logic            busy,
   output logic            rsp_strobe,
   output cmd_type         cmd
);

   typedef enum logic [13:0] {
      S_IDLE      = 14'b00000000000001,
      S_DISPATCH  = 14'b00000000000010,
      S_MOD       = 14'b00000000000100,
      S_MOD_APPLY = 14'b00000000001000,
      S_TICK_ADD  = 14'b00000000010000,
      S_BRANCH    = 14'b00000000100000,
      S_FWD_WAIT  = 14'b00000001000000,
      S_FWD_STEP  = 14'b00000010000000,
      S_BWD_CHECK = 14'b00000100000000,
      S_BWD_WAIT  = 14'b00001000000000,
      S_BWD_APPLY = 14'b00010000000000,
      S_SUM       = 14'b00100000000000,
      S_SUM_DRAIN = 14'b01000000000000,
      S_FINISH    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.dispatch = 1'b1;
            priority if (status.op == OP_TICK) begin
               state_in = S_TICK_ADD;
            end else if (status.op == OP_STEP && !status.step_zero) begin
               state_in = S_MOD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_MOD: begin
            if (status.mod_done) begin
               state_in = S_MOD_APPLY;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         S_MOD_APPLY: begin
            cmd.mod_apply = 1'b1;
            state_in      = S_FINISH;
         end
         S_TICK_ADD: begin
            cmd.tick_add = 1'b1;
            state_in     = S_BRANCH;
         end
         S_BRANCH: begin
            if (status.ft_neg) begin
               state_in = S_BWD_CHECK;
            end else begin
               // fetch the current frame's length once for all forward steps
               cmd.rd_cur = 1'b1;
               state_in   = S_FWD_WAIT;
            end
         end
         S_FWD_WAIT: begin
            state_in = S_FWD_STEP;
         end
         S_FWD_STEP: begin
            if (status.fwd_go) begin
               cmd.fwd_step = 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_BWD_CHECK: begin
            if (status.bwd_go) begin
               cmd.rd_back = 1'b1;
               state_in    = S_BWD_WAIT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_BWD_WAIT: begin
            state_in = S_BWD_APPLY;
         end
         S_BWD_APPLY: begin
            cmd.bwd_apply = 1'b1;
            state_in      = status.wrap_loop ? S_SUM : S_BWD_CHECK;
         end
         S_SUM: begin
            if (status.sum_more) begin
               cmd.sum_issue = 1'b1;
            end else begin
               state_in = S_SUM_DRAIN;
            end
         end
         S_SUM_DRAIN: begin
            // wait for the last durations to land in the accumulator
            if (!status.pipe_busy) begin
               cmd.sum_final = 1'b1;
               state_in      = S_BWD_CHECK;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.finish;
      end
   end

endmodule
`default_nettype wire

// File: src/sfs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite frame sequencer datapath
// Frame and sequence timers, duration table, speed multiplier, remainder
// unit and the backward-wrap accumulator, driven by controller commands.
// ----------------------------------------------------------------------------
module sfs_datapath
   import sfs_pkg::*;
#(
   parameter int MAX_FRAMES  = MAX_FRAMES_DEFAULT,
   parameter int MAX_CATCHUP = MAX_CATCHUP_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire cmd_type            cmd,
   output status_type              status,
   input  wire logic [2:0]         req_operation,
   input  wire logic signed [20:0] req_elapsed_us,
   input  wire logic [5:0]         req_frame_slot,
   input  wire logic [15:0]        req_duration_ms,
   input  wire logic signed [7:0]  req_step_amount,
   input  wire logic signed [31:0] req_frame_time_us,
   output logic [5:0]              rsp_frame_index,
   output logic                    rsp_frame_changed,
   output logic                    rsp_playing,
   output logic                    rsp_sequence_done,
   output logic [15:0]             rsp_loop_count,
   output logic signed [31:0]      rsp_time_in_frame_us,
   output logic signed [31:0]      rsp_sequence_time_us
);

   localparam int AW      = $clog2(MAX_FRAMES);
   localparam int STEP_W  = $clog2(MAX_CATCHUP + 1);
   localparam int PROD_W  = 37;
   localparam int DELTA_W = PROD_W - 8;
   localparam int ACC_W   = 34;
   localparam logic signed [ACC_W-1:0] ACC_CAP = {{(ACC_W-32){1'b0}}, 32'h8000_0000};

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-32:0] top;
      top = v[ACC_W-1:31];
      if (top == '0 || top == '1) begin
         return $signed(v[31:0]);
      end else if (v[ACC_W-1]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7FFF_FFFF;
      end
   endfunction

   // captured item
   logic [2:0]         op_ff;
   logic signed [20:0] elapsed_ff;
   logic [5:0]         slot_ff;
   logic [15:0]        dms_ff;
   logic signed [7:0]  amount_ff;
   logic signed [31:0] ftin_ff;

   // sequencer state
   logic [FRAME_W-1:0] frame_ff, frame_in, prev_ff;
   logic signed [31:0] ftime_ff, ftime_in, stime_ff, stime_in;
   logic [15:0]        loops_ff, loops_in;
   logic               play_ff, play_in, done_ff, done_in;

   // working registers
   logic signed [PROD_W-1:0] product_ff;
   logic [DUR_US_W-1:0]      dur_ff;
   logic                     rd1_ff, s1_ff, s2_ff;
   logic [STEP_W-1:0]        steps_ff, steps_in;
   logic [FRAME_W-1:0]       sum_k_ff, sum_k_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [MOD_BITS-1:0]      mag_ff, mag_in;
   logic [FRAME_W-1:0]       rem_ff, rem_in;
   logic [MOD_CNT_W-1:0]     mod_cnt_ff, mod_cnt_in;
   logic                     neg_ff, neg_in;

   // combinational terms
   logic [FRAME_W-1:0]       len, len_m1, idx_back, frame_sel, mod_res;
   logic                     rd_en, wr_en, steps_left, fwd_ge;
   logic [AW-1:0]            rd_addr;
   logic [DUR_MS_W-1:0]      rd_data, ms_eff;
   logic [DUR_US_W-1:0]      dur_calc;
   logic signed [DELTA_W-1:0] delta;
   logic signed [ACC_W-1:0]  ft_sum, st_sum, acc_sum, acc_step;
   logic signed [31:0]       fwd_ft, bwd_ft;
   logic signed [MOD_BITS:0] mod_v;
   logic [MOD_BITS-1:0]      mod_mag;
   logic [FRAME_W:0]         mod_trial, len_x;

   // effective length: zero acts as one, clamp to the table size
   always_comb begin
      if (cfg.seq_length == '0) begin
         len = FRAME_W'(1);
      end else if (int'(cfg.seq_length) > MAX_FRAMES) begin
         len = FRAME_W'(MAX_FRAMES);
      end else begin
         len = cfg.seq_length;
      end
   end

   assign len_m1   = len - FRAME_W'(1);
   assign idx_back = (frame_ff == '0) ? (cfg.looping ? len_m1 : '0) : frame_ff - FRAME_W'(1);

   // duration table
   assign rd_en = cmd.rd_cur || cmd.rd_back || cmd.sum_issue;
   always_comb begin
      priority if (cmd.rd_back) begin
         frame_sel = idx_back;
      end else if (cmd.sum_issue) begin
         frame_sel = sum_k_ff;
      end else begin
         frame_sel = frame_ff;
      end
   end
   assign rd_addr = AW'(frame_sel);
   assign wr_en   = cmd.dispatch && (op_ff == OP_LOAD) && (int'(slot_ff) < MAX_FRAMES);

   sfs_ram #(
      .WIDTH (DUR_MS_W),
      .DEPTH (MAX_FRAMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(slot_ff)),
      .wr_data (dms_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // a zero duration counts as one millisecond
   assign ms_eff   = (rd_data == '0) ? DUR_MS_W'(1) : rd_data;
   assign dur_calc = {{(DUR_US_W-DUR_MS_W){1'b0}}, ms_eff} * DUR_US_W'(US_PER_MS);

   // tick arithmetic: product floored by an arithmetic shift
   assign delta  = $signed(product_ff[PROD_W-1:8]);
   assign ft_sum = ACC_W'(ftime_ff) + ACC_W'(delta);
   assign st_sum = ACC_W'(stime_ff) + ACC_W'(delta);

   assign steps_left = (steps_ff < STEP_W'(MAX_CATCHUP));
   assign fwd_ge     = $signed({ftime_ff[31], ftime_ff}) >=
                       $signed({{(33-DUR_US_W){1'b0}}, dur_ff});
   assign fwd_ft     = ftime_ff - $signed({{(32-DUR_US_W){1'b0}}, dur_ff});
   assign bwd_ft     = ftime_ff + $signed({{(32-DUR_US_W){1'b0}}, dur_ff});

   // saturate the running sum just past the 32-bit range; terms are positive
   assign acc_sum  = acc_ff + $signed({{(ACC_W-DUR_US_W){1'b0}}, dur_ff});
   assign acc_step = (acc_sum > ACC_CAP) ? ACC_CAP : acc_sum;

   // remainder unit: one quotient bit a cycle
   assign mod_v   = $signed({{(MOD_BITS+1-FRAME_W){1'b0}}, frame_ff}) +
                    (MOD_BITS+1)'(amount_ff);
   assign mod_mag = mod_v[MOD_BITS] ? MOD_BITS'(-mod_v) : MOD_BITS'(mod_v);
   assign mod_trial = {rem_ff, mag_ff[MOD_BITS-1]};
   assign len_x     = {1'b0, len};
   assign mod_res   = (neg_ff && rem_ff != '0) ? len - rem_ff : rem_ff;

   assign status.op        = op_ff;
   assign status.step_zero = (amount_ff == '0);
   assign status.mod_done  = (mod_cnt_ff == MOD_CNT_W'(MOD_BITS));
   assign status.ft_neg    = ftime_ff[31];
   assign status.fwd_go    = !ftime_ff[31] && fwd_ge && steps_left;
   assign status.bwd_go    = ftime_ff[31] && steps_left;
   assign status.wrap_loop = (frame_ff == '0) && cfg.looping;
   assign status.sum_more  = (sum_k_ff < frame_ff);
   assign status.pipe_busy = s1_ff || s2_ff;

   always_comb begin
      frame_in   = frame_ff;
      ftime_in   = ftime_ff;
      stime_in   = stime_ff;
      loops_in   = loops_ff;
      play_in    = play_ff;
      done_in    = done_ff;
      steps_in   = steps_ff;
      sum_k_in   = sum_k_ff;
      acc_in     = acc_ff;
      mag_in     = mag_ff;
      rem_in     = rem_ff;
      neg_in     = neg_ff;
      mod_cnt_in = mod_cnt_ff;

      if (s2_ff) begin
         acc_in = acc_step;
      end
      if (cmd.capture) begin
         done_in = 1'b0;
      end
      if (cmd.dispatch) begin
         unique case (op_ff)
            OP_RESTART: begin
               frame_in = '0;
               ftime_in = '0;
               stime_in = '0;
               loops_in = '0;
               play_in  = 1'b1;
            end
            OP_STEP: begin
               if (amount_ff != '0) begin
                  mag_in     = mod_mag;
                  neg_in     = mod_v[MOD_BITS];
                  rem_in     = '0;
                  mod_cnt_in = '0;
               end
            end
            OP_SET: begin
               frame_in = ({1'b0, slot_ff} > len_m1) ? len_m1 : {1'b0, slot_ff};
               ftime_in = ftin_ff;
            end
            default: begin
               frame_in = frame_ff;
            end
         endcase
      end
      if (cmd.mod_step) begin
         if (mod_trial >= len_x) begin
            rem_in = FRAME_W'(mod_trial - len_x);
         end else begin
            rem_in = mod_trial[FRAME_W-1:0];
         end
         mag_in     = {mag_ff[MOD_BITS-2:0], 1'b0};
         mod_cnt_in = mod_cnt_ff + MOD_CNT_W'(1);
      end
      if (cmd.mod_apply) begin
         frame_in = mod_res;
         ftime_in = '0;
      end
      if (cmd.tick_add) begin
         ftime_in = sat32(ft_sum);
         stime_in = sat32(st_sum);
         steps_in = '0;
      end
      if (cmd.fwd_step) begin
         ftime_in = fwd_ft;
         steps_in = steps_ff + STEP_W'(1);
         if (frame_ff + FRAME_W'(1) >= len) begin
            if (cfg.looping) begin
               frame_in = '0;
               stime_in = fwd_ft;
               loops_in = loops_ff + 16'd1;
            end else begin
               frame_in = len_m1;
               done_in  = 1'b1;
               play_in  = 1'b0;
            end
         end else begin
            frame_in = frame_ff + FRAME_W'(1);
         end
      end
      if (cmd.bwd_apply) begin
         frame_in = idx_back;
         ftime_in = bwd_ft;
         steps_in = steps_ff + STEP_W'(1);
         if (frame_ff == '0) begin
            if (cfg.looping) begin
               // sequence time restarts from the sum of all earlier frames
               loops_in = loops_ff + 16'd1;
               acc_in   = ACC_W'(bwd_ft);
               sum_k_in = '0;
            end else begin
               done_in = 1'b1;
               play_in = 1'b0;
            end
         end
      end
      if (cmd.sum_issue) begin
         sum_k_in = sum_k_ff + FRAME_W'(1);
      end
      if (cmd.sum_final) begin
         stime_in = sat32(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff   <= '0;
         ftime_ff   <= '0;
         stime_ff   <= '0;
         loops_ff   <= '0;
         play_ff    <= 1'b1;
         done_ff    <= 1'b0;
         steps_ff   <= '0;
         sum_k_ff   <= '0;
         mod_cnt_ff <= '0;
         rd1_ff     <= 1'b0;
         s1_ff      <= 1'b0;
         s2_ff      <= 1'b0;
      end else begin
         frame_ff   <= frame_in;
         ftime_ff   <= ftime_in;
         stime_ff   <= stime_in;
         loops_ff   <= loops_in;
         play_ff    <= play_in;
         done_ff    <= done_in;
         steps_ff   <= steps_in;
         sum_k_ff   <= sum_k_in;
         mod_cnt_ff <= mod_cnt_in;
         rd1_ff     <= rd_en;
         s1_ff      <= cmd.sum_issue;
         s2_ff      <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      if (cmd.capture) begin
         op_ff      <= req_operation;
         elapsed_ff <= req_elapsed_us;
         slot_ff    <= req_frame_slot;
         dms_ff     <= req_duration_ms;
         amount_ff  <= req_step_amount;
         ftin_ff    <= req_frame_time_us;
         prev_ff    <= frame_ff;
      end
      if (cmd.dispatch) begin
         product_ff <= elapsed_ff * cfg.speed;
      end
      if (rd1_ff) begin
         dur_ff <= dur_calc;
      end
      if (cmd.finish) begin
         rsp_frame_index      <= frame_ff[5:0];
         rsp_frame_changed    <= (frame_ff != prev_ff);
         rsp_playing          <= play_ff;
         rsp_sequence_done    <= done_ff;
         rsp_loop_count       <= loops_ff;
         rsp_time_in_frame_us <= ftime_ff;
         rsp_sequence_time_us <= stime_ff;
      end
   end

   a_frame_in_table: assert property (@(posedge clock) disable iff (reset)
      int'(frame_ff) < MAX_FRAMES)
      else $error("frame index beyond the duration table");

   a_catchup_bound: assert property (@(posedge clock) disable iff (reset)
      int'(steps_ff) <= MAX_CATCHUP)
      else $error("catch-up steps exceed the limit");

   a_bwd_only_negative: assert property (@(posedge clock) disable iff (reset)
      cmd.bwd_apply |-> ftime_ff[31])
      else $error("backward step with non-negative frame time");

endmodule
`default_nettype wire

// File: src/sprite_frame_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Animation frame timer over a table of per-frame durations.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------
//   request  | start, busy             | req_operation .. req_frame_time_us
//   result   | rsp_strobe (one cycle)  | rsp_frame_index .. rsp_sequence_time_us
//   config   | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// One item at a time; busy is high from acceptance until the result cycle,
// in which a new item may already be accepted.
// Load, restart, set timing and unused operations go from dispatch straight
// to the result; step frames adds the bit-serial remainder. Tick steps
// forward through catch-up steps; backward each step goes through the
// duration table's read pipeline, and a looping wrap sums the earlier
// durations, one table read a cycle.
// Synchronous reset restores the controller, configuration and timers; no clearing pass.
// The receiver cannot stall: each result is valid for its strobe cycle only.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer
   import sfs_pkg::*;
#(
   parameter int MAX_FRAMES  = MAX_FRAMES_DEFAULT,
   parameter int MAX_CATCHUP = MAX_CATCHUP_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_operation,
   input  wire logic signed [20:0] req_elapsed_us,
   input  wire logic [5:0]         req_frame_slot,
   input  wire logic [15:0]        req_duration_ms,
   input  wire logic signed [7:0]  req_step_amount,
   input  wire logic signed [31:0] req_frame_time_us,
   // result
   output logic                    rsp_strobe,
   output logic [5:0]              rsp_frame_index,
   output logic                    rsp_frame_changed,
   output logic                    rsp_playing,
   output logic                    rsp_sequence_done,
   output logic [15:0]             rsp_loop_count,
   output logic signed [31:0]      rsp_time_in_frame_us,
   output logic signed [31:0]      rsp_sequence_time_us,
   // configuration
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   sfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   sfs_datapath #(
      .MAX_FRAMES  (MAX_FRAMES),
      .MAX_CATCHUP (MAX_CATCHUP)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .cmd                  (cmd),
      .status               (status),
      .req_operation        (req_operation),
      .req_elapsed_us       (req_elapsed_us),
      .req_frame_slot       (req_frame_slot),
      .req_duration_ms      (req_duration_ms),
      .req_step_amount      (req_step_amount),
      .req_frame_time_us    (req_frame_time_us),
      .rsp_frame_index      (rsp_frame_index),
      .rsp_frame_changed    (rsp_frame_changed),
      .rsp_playing          (rsp_playing),
      .rsp_sequence_done    (rsp_sequence_done),
      .rsp_loop_count       (rsp_loop_count),
      .rsp_time_in_frame_us (rsp_time_in_frame_us),
      .rsp_sequence_time_us (rsp_sequence_time_us)
   );

   a_release_with_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   a_result_after_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(busy))
      else $error("result without an item in progress");

endmodule
`default_nettype wire

// File: dv/sprite_frame_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer testbench
// Drives operations through the start/busy command port and the timing
// registers through the APB port. A behavioural model of the frame timer
// predicts every result, and each strobed result is checked field by field.
// Directed cases come first, then random playback in phases with fresh
// register settings.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_test
   import sfs_pkg::*;
;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int CATCHUP_STEPS = MAX_CATCHUP_DEFAULT;
   localparam int TABLE_DEPTH   = MAX_FRAMES_DEFAULT;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 135;
   localparam int REPORT_LIMIT  = 10;

   localparam int US_MAX = 32'sh7FFF_FFFF;
   localparam int US_MIN = 32'sh8000_0000;

   localparam logic [2:0] OP_RSVD_LO  = 3'd5;
   localparam logic [2:0] OP_RSVD_MID = 3'd6;
   localparam logic [2:0] OP_RSVD_HI  = 3'd7;

   localparam logic [PADDR_W-1:0] CSR_SEQ_LENGTH = 4'h0;
   localparam logic [PADDR_W-1:0] CSR_LOOPING    = 4'h4;
   localparam logic [PADDR_W-1:0] CSR_SPEED      = 4'h8;

   typedef struct {
      logic [2:0]         op;
      logic signed [20:0] elapsed_us;
      logic [5:0]         frame_slot;
      logic [15:0]        duration_ms;
      logic signed [7:0]  step_amount;
      logic signed [31:0] frame_time_us;
   } sprite_cmd_type;

   typedef struct {
      logic [5:0]         frame_index;
      logic               frame_changed;
      logic               playing;
      logic               sequence_done;
      logic [15:0]        loop_count;
      logic signed [31:0] time_in_frame_us;
      logic signed [31:0] sequence_time_us;
   } frame_status_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [2:0]          req_operation;
   logic signed [20:0]  req_elapsed_us;
   logic [5:0]          req_frame_slot;
   logic [15:0]         req_duration_ms;
   logic signed [7:0]   req_step_amount;
   logic signed [31:0]  req_frame_time_us;
   logic                rsp_strobe;
   logic [5:0]          rsp_frame_index;
   logic                rsp_frame_changed;
   logic                rsp_playing;
   logic                rsp_sequence_done;
   logic [15:0]         rsp_loop_count;
   logic signed [31:0]  rsp_time_in_frame_us;
   logic signed [31:0]  rsp_sequence_time_us;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [PDATA_W-1:0]  pwdata;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   // frame timer model state and register copies
   logic [15:0]         dur_ms_tbl [TABLE_DEPTH];
   int                  seq_frame;
   int                  frame_us_acc;
   int                  seq_us_acc;
   logic [15:0]         loops_seen;
   logic                play_on;
   logic [6:0]          len_reg;
   logic                loop_reg;
   logic signed [15:0]  speed_reg;

   frame_status_type    expected_status_q [$];
   frame_status_type    seen_status;
   frame_status_type    want_status;
   int                  fail_count;
   int                  cycle_count;
   bit                  gapless;

   sprite_frame_sequencer u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_elapsed_us       (req_elapsed_us),
      .req_frame_slot       (req_frame_slot),
      .req_duration_ms      (req_duration_ms),
      .req_step_amount      (req_step_amount),
      .req_frame_time_us    (req_frame_time_us),
      .rsp_strobe           (rsp_strobe),
      .rsp_frame_index      (rsp_frame_index),
      .rsp_frame_changed    (rsp_frame_changed),
      .rsp_playing          (rsp_playing),
      .rsp_sequence_done    (rsp_sequence_done),
      .rsp_loop_count       (rsp_loop_count),
      .rsp_time_in_frame_us (rsp_time_in_frame_us),
      .rsp_sequence_time_us (rsp_sequence_time_us),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Frame timer model
   // ------------------------------------------------------------------------
   function automatic void reset_model();
      foreach (dur_ms_tbl[i]) dur_ms_tbl[i] = '0;
      seq_frame    = 0;
      frame_us_acc = 0;
      seq_us_acc   = 0;
      loops_seen   = '0;
      play_on      = 1'b1;
      len_reg      = 7'd1;
      loop_reg     = 1'b1;
      speed_reg    = 16'sd256;
   endfunction

   function automatic int clamp_us(input longint v);
      if (v > longint'(US_MAX)) return US_MAX;
      if (v < longint'(US_MIN)) return US_MIN;
      return int'(v);
   endfunction

   function automatic int active_len();
      if (len_reg == 7'd0) return 1;
      if (int'(len_reg) > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(len_reg);
   endfunction

   function automatic longint frame_len_us(input int idx);
      longint ms;
      ms = longint'(dur_ms_tbl[idx]);
      if (ms < 1) ms = 1;
      return ms * US_PER_MS;
   endfunction

   function automatic void advance_tick(input longint elapsed, inout logic done);
      int     len;
      int     actual;
      longint d;
      longint flen;
      longint acc;
      len = active_len();
      // floor of the Q8.8 product
      d = (elapsed * longint'(speed_reg)) >>> 8;
      seq_us_acc   = clamp_us(longint'(seq_us_acc) + d);
      frame_us_acc = clamp_us(longint'(frame_us_acc) + d);
      if (frame_us_acc < 0) begin
         for (int i = 0; i < CATCHUP_STEPS && frame_us_acc < 0; i++) begin
            if (seq_frame == 0) begin
               actual = loop_reg ? len - 1 : 0;
               frame_us_acc = clamp_us(longint'(frame_us_acc) + frame_len_us(actual));
               seq_frame = actual;
               if (loop_reg) begin
                  // rebuild loop time from all frames ahead of the new one
                  acc = longint'(frame_us_acc);
                  for (int k = 0; k < seq_frame; k++) acc += frame_len_us(k);
                  seq_us_acc = clamp_us(acc);
                  loops_seen++;
               end else begin
                  done    = 1'b1;
                  play_on = 1'b0;
               end
            end else begin
               seq_frame--;
               frame_us_acc = clamp_us(longint'(frame_us_acc) + frame_len_us(seq_frame));
            end
         end
      end else begin
         // every forward step of a tick uses the starting frame's length
         flen = frame_len_us(seq_frame);
         for (int i = 0; i < CATCHUP_STEPS && longint'(frame_us_acc) >= flen; i++) begin
            seq_frame++;
            frame_us_acc = int'(longint'(frame_us_acc) - flen);
            if (seq_frame >= len) begin
               if (loop_reg) begin
                  seq_frame  = 0;
                  seq_us_acc = frame_us_acc;
                  loops_seen++;
               end else begin
                  seq_frame = len - 1;
                  done      = 1'b1;
                  play_on   = 1'b0;
               end
            end
         end
      end
   endfunction

   function automatic frame_status_type predict_status(input sprite_cmd_type c);
      frame_status_type s;
      int               prev;
      int               len;
      int               m;
      logic             done;
      prev = seq_frame;
      done = 1'b0;
      len  = active_len();
      case (c.op)
         OP_TICK: advance_tick(longint'(c.elapsed_us), done);
         OP_LOAD: dur_ms_tbl[c.frame_slot] = c.duration_ms;
         OP_RESTART: begin
            seq_frame    = 0;
            frame_us_acc = 0;
            seq_us_acc   = 0;
            loops_seen   = '0;
            play_on      = 1'b1;
         end
         OP_STEP: begin
            if (c.step_amount != 0) begin
               m = (seq_frame + int'(c.step_amount)) % len;
               if (m < 0) m += len;
               seq_frame    = m;
               frame_us_acc = 0;
            end
         end
         OP_SET: begin
            seq_frame    = (int'(c.frame_slot) > len - 1) ? len - 1 : int'(c.frame_slot);
            frame_us_acc = c.frame_time_us;
         end
         default: ;
      endcase
      s.frame_index      = 6'(seq_frame);
      s.frame_changed    = (seq_frame != prev);
      s.playing          = play_on;
      s.sequence_done    = done;
      s.loop_count       = loops_seen;
      s.time_in_frame_us = frame_us_acc;
      s.sequence_time_us = seq_us_acc;
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen_status.frame_index      = rsp_frame_index;
         seen_status.frame_changed    = rsp_frame_changed;
         seen_status.playing          = rsp_playing;
         seen_status.sequence_done    = rsp_sequence_done;
         seen_status.loop_count       = rsp_loop_count;
         seen_status.time_in_frame_us = rsp_time_in_frame_us;
         seen_status.sequence_time_us = rsp_sequence_time_us;
         if (expected_status_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: result strobed with no item outstanding, frame %0d",
                        $realtime, rsp_frame_index);
         end else begin
            want_status = expected_status_q.pop_front();
            if (seen_status.frame_index      !== want_status.frame_index      ||
                seen_status.frame_changed    !== want_status.frame_changed    ||
                seen_status.playing          !== want_status.playing          ||
                seen_status.sequence_done    !== want_status.sequence_done    ||
                seen_status.loop_count       !== want_status.loop_count       ||
                seen_status.time_in_frame_us !== want_status.time_in_frame_us ||
                seen_status.sequence_time_us !== want_status.sequence_time_us) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("%0t: status mismatch (expected / actual)", $realtime);
                  $display("   frame %0d / %0d  changed %0b / %0b  playing %0b / %0b",
                           want_status.frame_index, seen_status.frame_index,
                           want_status.frame_changed, seen_status.frame_changed,
                           want_status.playing, seen_status.playing);
                  $display("   done %0b / %0b  loops %0d / %0d",
                           want_status.sequence_done, seen_status.sequence_done,
                           want_status.loop_count, seen_status.loop_count);
                  $display("   frame_us %0d / %0d  seq_us %0d / %0d",
                           want_status.time_in_frame_us, seen_status.time_in_frame_us,
                           want_status.sequence_time_us, seen_status.sequence_time_us);
               end
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   function automatic sprite_cmd_type random_cmd(input logic [2:0] op);
      sprite_cmd_type c;
      // fields the operation ignores still carry noise
      c.op            = op;
      c.elapsed_us    = 21'($urandom());
      c.frame_slot    = 6'($urandom());
      c.duration_ms   = 16'($urandom());
      c.step_amount   = 8'($urandom());
      c.frame_time_us = 32'($urandom());
      return c;
   endfunction

   task automatic send_item(input sprite_cmd_type c);
      int gap;
      gap = gapless ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start             = 1'b1;
      req_operation     = c.op;
      req_elapsed_us    = c.elapsed_us;
      req_frame_slot    = c.frame_slot;
      req_duration_ms   = c.duration_ms;
      req_step_amount   = c.step_amount;
      req_frame_time_us = c.frame_time_us;
      do @(posedge clock); while (busy);
      expected_status_q.push_back(predict_status(c));
   endtask

   task automatic send_op(input logic [2:0] op);
      send_item(random_cmd(op));
   endtask

   task automatic send_tick(input int elapsed);
      sprite_cmd_type c;
      c = random_cmd(OP_TICK);
      c.elapsed_us = 21'(elapsed);
      send_item(c);
   endtask

   task automatic send_load(input int slot, input logic [15:0] ms);
      sprite_cmd_type c;
      c = random_cmd(OP_LOAD);
      c.frame_slot  = 6'(slot);
      c.duration_ms = ms;
      send_item(c);
   endtask

   task automatic send_step(input int amount);
      sprite_cmd_type c;
      c = random_cmd(OP_STEP);
      c.step_amount = 8'(amount);
      send_item(c);
   endtask

   task automatic send_set(input int slot, input int frame_us);
      sprite_cmd_type c;
      c = random_cmd(OP_SET);
      c.frame_slot    = 6'(slot);
      c.frame_time_us = frame_us;
      send_item(c);
   endtask

   // hold start low until every outstanding item has reported
   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (addr)
         CSR_SEQ_LENGTH: len_reg   = data[6:0];
         CSR_LOOPING:    loop_reg  = data[0];
         CSR_SPEED:      speed_reg = data[15:0];
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_playback(input int len, input logic loop_on, input int spd);
      wait_idle();
      write_csr(CSR_SEQ_LENGTH, PDATA_W'(7'(len)));
      write_csr(CSR_LOOPING, PDATA_W'(loop_on));
      write_csr(CSR_SPEED, PDATA_W'(16'(spd)));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_reset_state();
      send_op(OP_RSVD_LO);
      send_step(0);
      send_op(OP_RSVD_HI);
      send_op(OP_RESTART);
   endtask

   // every slot is written before the first tick can read it
   task automatic test_fill_durations();
      logic [15:0] ms;
      for (int slot = 0; slot < TABLE_DEPTH; slot++) begin
         if (slot == 0) ms = 16'd0;
         else if (slot == TABLE_DEPTH - 1) ms = 16'hFFFF;
         else if ($urandom_range(0, 15) == 0) ms = 16'($urandom());
         else ms = 16'($urandom_range(1, 6));
         send_load(slot, ms);
      end
   endtask

   task automatic test_forward_catchup();
      set_playback(4, 1'b1, 256);
      send_load(0, 16'd0);
      send_load(1, 16'd2);
      send_load(2, 16'd1);
      send_load(3, 16'd3);
      send_tick(0);
      send_tick(1500);
      send_tick(9000);
      send_tick(40000);
   endtask

   task automatic test_backward_wrap();
      set_playback(4, 1'b1, -256);
      send_tick(2500);
      send_tick(20000);
      set_playback(4, 1'b1, -32768);
      send_tick(1048575);
      send_tick(-1048576);
   endtask

   task automatic test_end_of_sequence();
      set_playback(3, 1'b0, 256);
      send_op(OP_RESTART);
      send_tick(10000);
      // time keeps running once stopped
      send_tick(500);
      send_op(OP_RESTART);
      set_playback(3, 1'b0, -256);
      send_tick(100);
   endtask

   task automatic test_steps_and_timing();
      set_playback(5, 1'b1, 256);
      send_step(64);
      send_step(-64);
      send_step(-128);
      send_set(63, US_MAX);
      send_tick(1000);
      send_set(0, US_MIN);
      send_tick(-1000);
      set_playback(0, 1'b1, 256);
      send_set(5, 1234);
      send_step(3);
      set_playback(127, 1'b1, 32767);
      send_set(63, 65534999);
      send_op(OP_RSVD_MID);
      // shrink the sequence under the current frame, then advance
      set_playback(4, 1'b1, 256);
      send_tick(1);
      send_step(127);
   endtask

   task automatic test_random_playback();
      sprite_cmd_type c;
      int             counted;
      int             len;
      int             spd;
      int             r;
      int             e;
      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 7))
            0:       len = 0;
            1:       len = $urandom_range(65, 127);
            2:       len = 64;
            3:       len = 1;
            4, 5:    len = $urandom_range(2, 8);
            default: len = $urandom_range(9, 63);
         endcase
         case ($urandom_range(0, 7))
            0:       spd = 256;
            1:       spd = -256;
            2:       spd = 32767;
            3:       spd = -32768;
            4:       spd = 0;
            5:       spd = int'(16'($urandom()));
            default: spd = int'($urandom_range(0, 2048)) - 1024;
         endcase
         set_playback(len, ($urandom_range(0, 9) < 7), spd);
         gapless = ($urandom_range(0, 3) == 0);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               c = random_cmd(OP_TICK);
               if ($urandom_range(0, 6) != 0) begin
                  e = $urandom_range(0, 12000);
                  if ($urandom_range(0, 3) == 0) e = -e;
                  c.elapsed_us = 21'(e);
               end
            end else if (r < 67) begin
               c = random_cmd(OP_LOAD);
               if ($urandom_range(0, 11) != 0) c.duration_ms = 16'($urandom_range(0, 8));
            end else if (r < 72) begin
               c = random_cmd(OP_RESTART);
            end else if (r < 82) begin
               c = random_cmd(OP_STEP);
               if ($urandom_range(0, 4) != 0)
                  c.step_amount = 8'(int'($urandom_range(0, 128)) - 64);
            end else if (r < 95) begin
               c = random_cmd(OP_SET);
               if ($urandom_range(0, 3) != 0)
                  c.frame_time_us = int'($urandom_range(0, 9000)) - 1000;
            end else begin
               c = random_cmd(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)));
            end
            send_item(c);
            if (c.op <= OP_SET) counted++;
         end
      end
      gapless = 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_operation     = OP_TICK;
      req_elapsed_us    = '0;
      req_frame_slot    = '0;
      req_duration_ms   = '0;
      req_step_amount   = '0;
      req_frame_time_us = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      fail_count        = 0;
      gapless           = 1'b0;
      reset_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_fill_durations();
      test_forward_catchup();
      test_backward_wrap();
      test_end_of_sequence();
      test_steps_and_timing();
      test_random_playback();

      wait_idle();
      repeat (20) @(posedge clock);
      fail_count += expected_status_q.size();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
